@@ src/lin_frame_receiver_unit_defines.svh @@
// assertion helpers for the lin frame receiver
`ifndef LIN_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LIN_FRAME_RECEIVER_UNIT_DEFINES_SVH

// checked on every edge out of reset
`define LINFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LINFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/linfr_pkg.sv @@
`timescale 1ns / 1ps
package linfr_pkg;

  localparam logic [5:0] IdMask         = 6'h3F;
  localparam logic [5:0] ClassicIdStart = 6'h3C;
  localparam logic [5:0] ShortIdLast    = 6'h1F;
  localparam logic [5:0] MidIdLast      = 6'h2F;
  localparam logic [7:0] SumGood        = 8'hFF;

  localparam logic [3:0] LenShort = 4'd2;
  localparam logic [3:0] LenMid   = 4'd4;
  localparam logic [3:0] LenLong  = 4'd8;

  localparam int CfgAddrW = 3;
  localparam logic CfgIdxClassic = 1'b0;

  typedef struct packed {
    logic [5:0]  frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } linfr_result_t;

  // end-around-carry add
  function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function automatic logic [3:0] length_of(input logic [5:0] id);
    logic [3:0] len;
    if (id <= ShortIdLast) len = LenShort;
    else if (id <= MidIdLast) len = LenMid;
    else len = LenLong;
    return len;
  endfunction

endpackage

@@ src/linfr_if.sv @@
`timescale 1ns / 1ps
interface linfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       framing_error;

  modport source (output valid, output rx_byte, output framing_error, input ready);
  modport sink   (input valid, input rx_byte, input framing_error, output ready);
endinterface

interface linfr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  frame_id;
  logic [3:0]  data_length;
  logic [63:0] payload;

  modport source (output valid, output frame_id, output data_length, output payload,
                  input ready);
  modport sink   (input valid, input frame_id, input data_length, input payload,
                  output ready);
endinterface

@@ src/lin_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// channel   | dir | fields                              | handshake
// in_ch     | in  | rx_byte[7:0], framing_error         | valid/ready
// out_ch    | out | frame_id[5:0], data_length[3:0],    | valid/ready
//           |     | payload[63:0]                       |
// cfg_*     | in  | classic_only at paddr 0 to 3        | apb, pready tied high
//
// one byte is taken every cycle while in_ready is high; a result goes from its checksum
// byte through the input register, then frame logic into the result register
// rst_n is synchronous, active low: frame tracking returns to idle, classic_only to 0
// a held result blocks the input register only; the input still takes an item
// whenever the input register is empty or moves on in the same cycle
module lin_frame_receiver_unit import linfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  linfr_in_if.sink            in_ch,
  linfr_out_if.source         out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic          classic_only;
  linfr_result_t result;

  // configuration register block
  linfr_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .classic_only (classic_only)
  );

  // frame tracking: input register, position state, checksum, result register
  linfr_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .classic_only     (classic_only),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_rx_byte       (in_ch.rx_byte),
    .in_framing_error (in_ch.framing_error),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result       (result)
  );

  // unpack the result onto the channel
  assign out_ch.frame_id    = result.frame_id;
  assign out_ch.data_length = result.data_length;
  assign out_ch.payload     = result.payload;

endmodule

@@ src/linfr_cfg.sv @@
`timescale 1ns / 1ps
module linfr_cfg import linfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic                classic_only
);

  logic classic_r;
  logic classic_nxt;
  logic hit;

  assign hit    = (paddr[2] == CfgIdxClassic);
  assign pready = 1'b1;

  always_comb begin
    classic_nxt = classic_r;
    if (psel && penable && pwrite && hit) begin
      classic_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classic_r <= 1'b0;
    end else begin
      classic_r <= classic_nxt;
    end
  end

  assign prdata       = hit ? {31'd0, classic_r} : 32'd0;
  assign classic_only = classic_r;

endmodule

@@ src/linfr_core.sv @@
`timescale 1ns / 1ps
module linfr_core import linfr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          classic_only,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_framing_error,
  output logic          out_valid,
  input  logic          out_ready,
  output linfr_result_t out_result
);

  typedef enum logic [2:0] {
    POS_IDLE,
    POS_SYNC,
    POS_PID,
    POS_DATA,
    POS_CSUM
  } pos_t;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_fe_r;

  // frame state
  pos_t        pos_r, pos_nxt;
  logic [5:0]  id_r, id_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [63:0] store_r, store_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  linfr_result_t result_r, result_nxt;

  logic       adv;
  logic       fire;
  logic       emit;
  logic [7:0] total;
  logic       classic;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    pos_nxt      = pos_r;
    id_nxt       = id_r;
    pid_nxt      = pid_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    store_nxt    = store_r;
    emit         = 1'b0;
    classic      = classic_only || (id_r >= ClassicIdStart);
    total        = carry_add(sum_r, s1_byte_r);
    if (!classic) begin
      total = carry_add(total, pid_r);
    end
    result_nxt   = result_r;

    if (fire) begin
      if (s1_fe_r) begin
        // zero byte with framing error is a break
        pos_nxt = (s1_byte_r == 8'd0) ? POS_SYNC : POS_IDLE;
      end else begin
        case (pos_r)
          POS_SYNC: begin
            pos_nxt = POS_PID;
          end
          POS_PID: begin
            pid_nxt   = s1_byte_r;
            id_nxt    = s1_byte_r[5:0] & IdMask;
            cnt_nxt   = 4'd0;
            sum_nxt   = 8'd0;
            store_nxt = 64'd0;
            pos_nxt   = POS_DATA;
          end
          POS_DATA: begin
            for (int k = 0; k < 8; k++) begin
              if (cnt_r[2:0] == 3'(k)) begin
                store_nxt[8*k +: 8] = store_r[8*k +: 8] | s1_byte_r;
              end
            end
            sum_nxt = carry_add(sum_r, s1_byte_r);
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_nxt >= length_of(id_r)) begin
              pos_nxt = POS_CSUM;
            end
          end
          POS_CSUM: begin
            pos_nxt = POS_IDLE;
            if (total == SumGood) begin
              emit                   = 1'b1;
              result_nxt.frame_id    = id_r;
              result_nxt.data_length = length_of(id_r);
              result_nxt.payload     = store_r;
            end
          end
          default: begin
            pos_nxt = POS_IDLE;
          end
        endcase
      end
    end

    out_valid_nxt = adv ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= POS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_fe_r   <= in_framing_error;
    end
    id_r     <= id_nxt;
    pid_r    <= pid_nxt;
    cnt_r    <= cnt_nxt;
    sum_r    <= sum_nxt;
    store_r  <= store_nxt;
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

@@ src/linfr_checker.sv @@
`timescale 1ns / 1ps
`include "lin_frame_receiver_unit_defines.svh"
module linfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  data_length,
  input logic [63:0] payload
);

  `LINFR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(payload),
                "result dropped while stalled")
  `LINFR_ASSERT(a_len,
                out_valid |-> (data_length == 4'd2 || data_length == 4'd4 || data_length == 4'd8),
                "bad data length")
  `LINFR_ASSERT(a_pad,
                out_valid |-> (data_length != 4'd2 || payload[63:16] == 48'd0) &&
                              (data_length != 4'd4 || payload[63:32] == 32'd0),
                "unused payload bytes not zero")
  `LINFR_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind lin_frame_receiver_unit linfr_checker u_linfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .data_length (out_ch.data_length),
  .payload     (out_ch.payload)
);
